@@ design/iirdf2_pkg.sv @@
// ----------------------------------------------------------------------------
// iirdf2_pkg
// shared types, constants and the control program of the direct form ii filter
// ----------------------------------------------------------------------------
package iirdf2_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int STATE_W       = 24;
  localparam int COEF_W        = 18;
  localparam int FRAC_W        = 14;
  localparam int PROD_W        = COEF_W + STATE_W;
  localparam int ACC_W         = 32;
  localparam int NUM_REGS      = 7;
  localparam int REG_IDX_W     = 3;
  localparam int ORDER_DEFAULT = 2;
  localparam int ORDER_MAX     = 3;
  localparam int STEP_W        = 4;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);

  typedef logic [STEP_W-1:0] step_t;

  // register indexes of the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0, REG_B1, REG_B2, REG_B3, REG_A1, REG_A2, REG_A3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_MAC_FB, OP_FORM_W, OP_MAC_FF, OP_DONE
  } op_t;

  // multiplier operand: new state value or a delay tap
  typedef enum logic [1:0] {
    TAP_W0, TAP_D1, TAP_D2, TAP_D3
  } tap_t;

  typedef enum logic [1:0] {
    JC_NONE, JC_ORDER_LT2, JC_ORDER_LT3
  } jc_t;

  typedef struct packed {
    op_t      op;
    reg_idx_t coef;
    tap_t     tap;
    jc_t      jc;
    step_t    target;
  } ucode_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
  } mac_ctl_t;

  typedef enum logic {
    SEQ_IDLE, SEQ_RUN
  } seq_state_t;

  localparam step_t STEP_FB1     = 4'd0;
  localparam step_t STEP_FB2     = 4'd1;
  localparam step_t STEP_FB3     = 4'd2;
  localparam step_t STEP_WAIT_FB = 4'd3;
  localparam step_t STEP_FORM    = 4'd4;
  localparam step_t STEP_FF0     = 4'd5;
  localparam step_t STEP_FF1     = 4'd6;
  localparam step_t STEP_FF2     = 4'd7;
  localparam step_t STEP_FF3     = 4'd8;
  localparam step_t STEP_WAIT_FF = 4'd9;
  localparam step_t STEP_DONE    = 4'd10;

  // control program, one word per step
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t uw;
    uw = '{op: OP_DONE, coef: REG_B0, tap: TAP_W0, jc: JC_NONE, target: STEP_DONE};
    unique case (s)
      STEP_FB1:     uw = '{OP_MAC_FB, REG_A1, TAP_D1, JC_ORDER_LT2, STEP_WAIT_FB};
      STEP_FB2:     uw = '{OP_MAC_FB, REG_A2, TAP_D2, JC_ORDER_LT3, STEP_WAIT_FB};
      STEP_FB3:     uw = '{OP_MAC_FB, REG_A3, TAP_D3, JC_NONE, STEP_WAIT_FB};
      STEP_WAIT_FB: uw = '{OP_NOP, REG_B0, TAP_W0, JC_NONE, STEP_FORM};
      STEP_FORM:    uw = '{OP_FORM_W, REG_B0, TAP_W0, JC_NONE, STEP_FF0};
      STEP_FF0:     uw = '{OP_MAC_FF, REG_B0, TAP_W0, JC_NONE, STEP_FF1};
      STEP_FF1:     uw = '{OP_MAC_FF, REG_B1, TAP_D1, JC_ORDER_LT2, STEP_WAIT_FF};
      STEP_FF2:     uw = '{OP_MAC_FF, REG_B2, TAP_D2, JC_ORDER_LT3, STEP_WAIT_FF};
      STEP_FF3:     uw = '{OP_MAC_FF, REG_B3, TAP_D3, JC_NONE, STEP_WAIT_FF};
      STEP_WAIT_FF: uw = '{OP_NOP, REG_B0, TAP_W0, JC_NONE, STEP_DONE};
      default:      uw = '{OP_DONE, REG_B0, TAP_W0, JC_NONE, STEP_DONE};
    endcase
    return uw;
  endfunction

endpackage

@@ design/iirdf2_mac.sv @@
// ----------------------------------------------------------------------------
// iirdf2_mac
// registered multiplier followed by a rounding accumulator
// ----------------------------------------------------------------------------
module iirdf2_mac (
  input  logic                                     clk,
  input  logic                                     rst,
  input  iirdf2_pkg::mac_ctl_t                     ctl,
  input  logic signed [iirdf2_pkg::COEF_W-1:0]     coef,
  input  logic signed [iirdf2_pkg::STATE_W-1:0]    operand,
  output logic signed [iirdf2_pkg::ACC_W-1:0]      acc
);
  import iirdf2_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic signed [PROD_W-1:0] prod_shr;
  logic signed [ACC_W-1:0]  rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PROD_W'(coef * operand);
    end
  end

  // round half up: floor(p / 2^14) plus the bit just below the cut
  always_comb begin
    prod_shr = prod >>> FRAC_W;
    rnd      = ACC_W'(prod_shr) + ACC_W'(prod[FRAC_W-1]);
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + rnd;
    end
  end

endmodule

@@ design/iir_filter_direct_form_two_core.sv @@
// ----------------------------------------------------------------------------
// iir_filter_direct_form_two_core
// direct form ii iir filter, fixed point, one shared multiply-accumulate
// ----------------------------------------------------------------------------
// Each accepted sample x forms w0 = sat24(x - sum a[m]*w[m]) and delivers
// y = sat16(b0*w0 + sum b[m]*w[m]) for m = 1..ORDER, then pushes w0 into the
// delay line (or clears it when tlast marks the end of a block). Coefficients
// are signed Q3.14 and already normalized; each product is rounded half up to
// an integer. A small control program steps one 18x24 multiplier through the
// taps. No new sample is taken until the previous one has finished and its
// result has been written to the output register, and a sample cannot finish
// while the result before it is still unclaimed there. A finished result
// waits in the output register while the next sample is taken; m_tuser flags
// saturation of w0 or y. Coefficient writes are accepted on every cycle and
// must happen while no sample is in flight.
module iir_filter_direct_form_two_core #(
  parameter int ORDER = iirdf2_pkg::ORDER_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input samples
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [iirdf2_pkg::SAMPLE_W-1:0]       s_tdata,   // [15:0] sample_in
  input  logic                                  s_tlast,   // block_last
  // filtered samples
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [iirdf2_pkg::SAMPLE_W-1:0]       m_tdata,   // [15:0] sample_out
  output logic                                  m_tlast,   // out_last
  output logic                                  m_tuser,   // [0] clipped
  // coefficient writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [iirdf2_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [iirdf2_pkg::COEF_W-1:0]         cfg_data
);
  import iirdf2_pkg::*;

  localparam int DIFF_W = ACC_W + 1;

  // sequencer
  seq_state_t state, state_next;
  step_t      step, step_next;
  ucode_t     uw;
  logic       jump_taken;
  logic       in_fire;
  logic       done_fire;
  mac_ctl_t   mac_ctl;

  // datapath
  logic signed [COEF_W-1:0]   coef [NUM_REGS];
  logic signed [STATE_W-1:0]  delay_line [ORDER];
  logic signed [SAMPLE_W-1:0] x;
  logic                       last;
  logic                       clip;
  logic signed [STATE_W-1:0]  w0;
  logic signed [STATE_W-1:0]  operand;
  logic signed [ACC_W-1:0]    acc;
  logic signed [DIFF_W-1:0]   diff;
  logic                       w_ovf;
  logic signed [STATE_W-1:0]  w_sat;
  logic                       y_ovf;
  logic signed [SAMPLE_W-1:0] y_sat;

  // output register
  logic                       out_valid;
  logic [SAMPLE_W-1:0]        out_data;
  logic                       out_last;
  logic                       out_clip;

  assign uw        = ucode_rom(step);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;

  // conditional jumps skip the taps above the filter order
  assign jump_taken = (uw.jc == JC_ORDER_LT2 && ORDER < 2) ||
                      (uw.jc == JC_ORDER_LT3 && ORDER < 3);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (s_tvalid) state_next = SEQ_RUN;
      end
      SEQ_RUN: begin
        if (done_fire) state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready        = 1'b0;
    done_fire       = 1'b0;
    step_next       = step;
    mac_ctl.mul_en  = 1'b0;
    mac_ctl.acc_clr = 1'b0;
    unique case (state)
      SEQ_IDLE: begin
        s_tready        = 1'b1;
        step_next       = STEP_FB1;
        mac_ctl.acc_clr = 1'b1;
      end
      SEQ_RUN: begin
        mac_ctl.mul_en  = (uw.op == OP_MAC_FB) || (uw.op == OP_MAC_FF);
        mac_ctl.acc_clr = (uw.op == OP_FORM_W);
        if (uw.op == OP_DONE) begin
          // hold the last step while the previous result is still unclaimed
          done_fire = !out_valid || m_tready;
        end else if (jump_taken) begin
          step_next = uw.target;
        end else begin
          step_next = step + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      step  <= STEP_FB1;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // coefficient registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef[i] <= (i == int'(REG_B0)) ? COEF_ONE : '0;
      end
    end else if (cfg_valid && cfg_ready && cfg_index < REG_IDX_W'(NUM_REGS)) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // multiplier operand select
  always_comb begin
    operand = w0;
    for (int m = 0; m < ORDER; m++) begin
      if (uw.tap == tap_t'(2'(m + 1))) operand = delay_line[m];
    end
  end

  iirdf2_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .coef    (coef[uw.coef]),
    .operand (operand),
    .acc     (acc)
  );

  // w0 = x - feedback sum, saturated to the state width
  always_comb begin
    diff  = DIFF_W'(x) - DIFF_W'(acc);
    w_ovf = !((&diff[DIFF_W-1:STATE_W-1]) || !(|diff[DIFF_W-1:STATE_W-1]));
    if (w_ovf) begin
      w_sat = diff[DIFF_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      w_sat = diff[STATE_W-1:0];
    end
  end

  // y saturated to the sample width
  always_comb begin
    y_ovf = !((&acc[ACC_W-1:SAMPLE_W-1]) || !(|acc[ACC_W-1:SAMPLE_W-1]));
    if (y_ovf) begin
      y_sat = acc[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y_sat = acc[SAMPLE_W-1:0];
    end
  end

  // sample capture and new state value
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x    <= s_tdata;
      last <= s_tlast;
      clip <= 1'b0;
    end else if (state == SEQ_RUN && uw.op == OP_FORM_W) begin
      w0   <= w_sat;
      clip <= w_ovf;
    end
  end

  // delay line: shift in w0, or clear at the end of a block
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < ORDER; m++) delay_line[m] <= '0;
    end else if (done_fire) begin
      if (last) begin
        for (int m = 0; m < ORDER; m++) delay_line[m] <= '0;
      end else begin
        for (int m = ORDER - 1; m > 0; m--) delay_line[m] <= delay_line[m-1];
        delay_line[0] <= w0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_data <= y_sat;
      out_last <= last;
      out_clip <= clip | y_ovf;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;
  assign m_tuser  = out_clip;

endmodule

@@ design/iirdf2_checker.sv @@
// ----------------------------------------------------------------------------
// iirdf2_checker
// port-level checks of the iir filter core, bound to the top level
// ----------------------------------------------------------------------------
module iirdf2_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [iirdf2_pkg::SAMPLE_W-1:0]     m_tdata,
  input logic                                m_tlast,
  input logic                                m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
    $stable(m_tuser))
    else $error("output changed while stalled");

  // one sample at a time: no transaction right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a sample is in work");

  // a new result only appears at the end of a sample's work
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without work in progress");

endmodule

bind iir_filter_direct_form_two_core iirdf2_checker u_iirdf2_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
